>>> hw/rtl/dtpwm_pkg.sv
// Shared types and constants for the dead-time PWM pair generator.
`default_nettype none

package dtpwm_pkg;

  // Field and register widths
  localparam int ClockW    = 28;
  localparam int FreqW     = 24;
  localparam int DeadW     = 10;
  localparam int CountOutW = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 28;
  localparam int StatusW   = 2;

  // Defaults and reset values
  localparam int CounterBitsDef = 16;
  localparam int ResetClock     = 160000000;
  localparam int ResetPeriod    = 1600;
  // Width needed to hold the reset period
  localparam int ResetPeriodW   = 11;

  typedef enum logic [1:0] {
    ActNone   = 2'd0,
    ActLow    = 2'd1,
    ActHigh   = 2'd2,
    ActToggle = 2'd3
  } act_e;

  typedef struct packed {
    act_e zero;
    act_e first;
    act_e second;
  } act_set_t;

  typedef enum logic [StatusW-1:0] {
    StatOk     = 2'd0,
    StatReject = 2'd1,
    StatSat    = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgClockRate  = 3'd0,
    CfgZeroActA   = 3'd1,
    CfgFirstActA  = 3'd2,
    CfgSecondActA = 3'd3,
    CfgZeroActB   = 3'd4,
    CfgFirstActB  = 3'd5,
    CfgSecondActB = 3'd6
  } cfg_idx_e;

endpackage

`default_nettype wire

>>> hw/rtl/dead_time_pwm_pair_generator.sv
// Top level of the complementary PWM pair generator with dead time.
`default_nettype none

// Each input transfer is either a tick or an update. A tick advances the
// up-counter over 0..period-1 and applies the configured zero and compare
// actions to both outputs. Its result is registered and presented in the
// cycle after the transfer, so one tick per clock is taken while the result
// side keeps up and no update is running. An update runs clock_rate_hz /
// freq_hz through a restoring divider, one quotient bit per cycle, then
// saturates the period, checks the dead time and builds the four compare
// points in three more steps. The result is presented after all 28 quotient
// bits, the quotient handover and the three steps; the input is stalled for
// that whole time. An update with zero frequency is rejected and answered at
// once. New period and compares sit in shadow registers and take effect when
// the counter next wraps to zero.
// Status: 0 ok, 1 update rejected (zero frequency, or dead time not below the
// period), 2 period clamped to 2^CounterBits-1. Configuration writes are
// expected only while the block is idle; reset restores 160 MHz, a 1600-tick
// period, zero compares and low output levels.
module dead_time_pwm_pair_generator #(
  parameter int CounterBits = dtpwm_pkg::CounterBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [dtpwm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [dtpwm_pkg::CfgDataW-1:0]  cfg_data_i,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            action_i,
  input  wire logic [dtpwm_pkg::FreqW-1:0]     freq_hz_i,
  input  wire logic [dtpwm_pkg::DeadW-1:0]     dead_time_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 pwm_a_o,
  output logic                                 pwm_b_o,
  output logic [dtpwm_pkg::CountOutW-1:0]      count_o,
  output logic                                 period_start_o,
  output logic [dtpwm_pkg::StatusW-1:0]        status_o
);

  // Counter wide enough for the parameter and for the reset period
  localparam int CntW = (CounterBits > dtpwm_pkg::ResetPeriodW) ?
                        CounterBits : dtpwm_pkg::ResetPeriodW;
  // Compare points reach period+1, so one bit more
  localparam int CmpW = CntW + 1;
  localparam int QW   = (dtpwm_pkg::ClockW > CntW) ? dtpwm_pkg::ClockW : CntW;
  localparam logic [QW-1:0] PeriodMax = QW'((64'd1 << CounterBits) - 64'd1);

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StSat,
    StChk,
    StCmp
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [dtpwm_pkg::ClockW-1:0] clk_rate_q, clk_rate_d;
  dtpwm_pkg::act_set_t          act_a_q, act_a_d;
  dtpwm_pkg::act_set_t          act_b_q, act_b_d;

  // timer state
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] act_per_q, act_per_d;
  logic [CntW-1:0] shd_per_q, shd_per_d;
  logic [CmpW-1:0] act_cmp_q [4];
  logic [CmpW-1:0] act_cmp_d [4];
  logic [CmpW-1:0] shd_cmp_q [4];
  logic [CmpW-1:0] shd_cmp_d [4];
  logic            lvl_a_q, lvl_a_d;
  logic            lvl_b_q, lvl_b_d;

  // update working registers
  logic [dtpwm_pkg::DeadW-1:0] dead_q, dead_d;
  logic [CntW-1:0]             per_q, per_d;
  logic [CntW-1:0]             diff_q, diff_d;
  logic                        sat_q, sat_d;
  logic                        rej_q, rej_d;

  // result register
  logic                             out_valid_q, out_valid_d;
  logic                             out_a_q, out_a_d;
  logic                             out_b_q, out_b_d;
  logic [dtpwm_pkg::CountOutW-1:0]  out_cnt_q, out_cnt_d;
  logic                             out_pstart_q, out_pstart_d;
  dtpwm_pkg::status_e               out_stat_q, out_stat_d;

  // divider
  logic                        div_start;
  logic                        div_done;
  logic [dtpwm_pkg::ClockW-1:0] div_quo;

  // tick datapath
  logic            in_take;
  logic            wrap;
  logic [CntW-1:0] cnt_next;
  logic [CmpW-1:0] cnt_ext;
  logic [CmpW-1:0] eff_cmp [4];
  logic            lvl_a_next, lvl_b_next;

  // update datapath
  logic [QW-1:0]   quo_ext;
  logic [CntW-1:0] dead_ext;
  logic [CntW-1:0] half;

  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_take    = in_valid_i && !in_stall_o;

  // advance or wrap the counter; shadows become active on the wrap
  always_comb begin
    wrap     = ({1'b0, cnt_q} + 1'b1) >= {1'b0, act_per_q};
    cnt_next = wrap ? '0 : cnt_q + 1'b1;
    cnt_ext  = CmpW'(cnt_next);
    for (int i = 0; i < 4; i++) begin
      eff_cmp[i] = wrap ? shd_cmp_q[i] : act_cmp_q[i];
    end
  end

  dtpwm_chan #(
    .CmpW (CmpW)
  ) u_chan_a (
    .level_i      (lvl_a_q),
    .at_zero_i    (wrap),
    .count_i      (cnt_ext),
    .cmp_first_i  (eff_cmp[0]),
    .cmp_second_i (eff_cmp[1]),
    .act_i        (act_a_q),
    .level_o      (lvl_a_next)
  );

  dtpwm_chan #(
    .CmpW (CmpW)
  ) u_chan_b (
    .level_i      (lvl_b_q),
    .at_zero_i    (wrap),
    .count_i      (cnt_ext),
    .cmp_first_i  (eff_cmp[2]),
    .cmp_second_i (eff_cmp[3]),
    .act_i        (act_b_q),
    .level_o      (lvl_b_next)
  );

  dtpwm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (clk_rate_q),
    .divisor_i  (freq_hz_i),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign quo_ext  = QW'(div_quo);
  assign dead_ext = CntW'(dead_q);
  assign half     = diff_q >> 1;

  always_comb begin
    state_d      = state_q;
    clk_rate_d   = clk_rate_q;
    act_a_d      = act_a_q;
    act_b_d      = act_b_q;
    cnt_d        = cnt_q;
    act_per_d    = act_per_q;
    shd_per_d    = shd_per_q;
    act_cmp_d    = act_cmp_q;
    shd_cmp_d    = shd_cmp_q;
    lvl_a_d      = lvl_a_q;
    lvl_b_d      = lvl_b_q;
    dead_d       = dead_q;
    per_d        = per_q;
    diff_d       = diff_q;
    sat_d        = sat_q;
    rej_d        = rej_q;
    out_a_d      = out_a_q;
    out_b_d      = out_b_q;
    out_cnt_d    = out_cnt_q;
    out_pstart_d = out_pstart_q;
    out_stat_d   = out_stat_q;
    out_valid_d  = out_valid_q && out_stall_i;
    div_start    = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dtpwm_pkg::CfgClockRate:  clk_rate_d     = cfg_data_i[dtpwm_pkg::ClockW-1:0];
        dtpwm_pkg::CfgZeroActA:   act_a_d.zero   = dtpwm_pkg::act_e'(cfg_data_i[1:0]);
        dtpwm_pkg::CfgFirstActA:  act_a_d.first  = dtpwm_pkg::act_e'(cfg_data_i[1:0]);
        dtpwm_pkg::CfgSecondActA: act_a_d.second = dtpwm_pkg::act_e'(cfg_data_i[1:0]);
        dtpwm_pkg::CfgZeroActB:   act_b_d.zero   = dtpwm_pkg::act_e'(cfg_data_i[1:0]);
        dtpwm_pkg::CfgFirstActB:  act_b_d.first  = dtpwm_pkg::act_e'(cfg_data_i[1:0]);
        dtpwm_pkg::CfgSecondActB: act_b_d.second = dtpwm_pkg::act_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end

    unique case (state_q)
      StIdle: begin
        if (in_take) begin
          if (!action_i) begin
            // tick: result goes out in the next cycle
            cnt_d   = cnt_next;
            lvl_a_d = lvl_a_next;
            lvl_b_d = lvl_b_next;
            if (wrap) begin
              act_per_d = shd_per_q;
              act_cmp_d = shd_cmp_q;
            end
            out_valid_d  = 1'b1;
            out_a_d      = lvl_a_next;
            out_b_d      = lvl_b_next;
            out_cnt_d    = dtpwm_pkg::CountOutW'(cnt_next);
            out_pstart_d = wrap;
            out_stat_d   = dtpwm_pkg::StatOk;
          end else if (freq_hz_i == '0) begin
            // zero frequency: reject without dividing
            out_valid_d  = 1'b1;
            out_a_d      = lvl_a_q;
            out_b_d      = lvl_b_q;
            out_cnt_d    = dtpwm_pkg::CountOutW'(cnt_q);
            out_pstart_d = 1'b0;
            out_stat_d   = dtpwm_pkg::StatReject;
          end else begin
            dead_d    = dead_time_i;
            div_start = 1'b1;
            state_d   = StDiv;
          end
        end
      end
      StDiv: begin
        if (div_done) begin
          state_d = StSat;
        end
      end
      StSat: begin
        // clamp the period to the counter range
        sat_d   = quo_ext > PeriodMax;
        per_d   = CntW'(sat_d ? PeriodMax : quo_ext);
        state_d = StChk;
      end
      StChk: begin
        rej_d   = dead_ext >= per_q;
        diff_d  = per_q - dead_ext;
        state_d = StCmp;
      end
      StCmp: begin
        if (!rej_q) begin
          shd_per_d    = per_q;
          shd_cmp_d[0] = '0;
          shd_cmp_d[1] = CmpW'(half);
          shd_cmp_d[2] = CmpW'(half) + CmpW'(dead_q);
          shd_cmp_d[3] = CmpW'(diff_q) + 1'b1;
        end
        out_valid_d  = 1'b1;
        out_a_d      = lvl_a_q;
        out_b_d      = lvl_b_q;
        out_cnt_d    = dtpwm_pkg::CountOutW'(cnt_q);
        out_pstart_d = 1'b0;
        out_stat_d   = rej_q ? dtpwm_pkg::StatReject :
                       sat_q ? dtpwm_pkg::StatSat : dtpwm_pkg::StatOk;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      clk_rate_q  <= dtpwm_pkg::ClockW'(dtpwm_pkg::ResetClock);
      act_a_q     <= '{zero: dtpwm_pkg::ActLow, first: dtpwm_pkg::ActHigh,
                       second: dtpwm_pkg::ActLow};
      act_b_q     <= '{zero: dtpwm_pkg::ActLow, first: dtpwm_pkg::ActHigh,
                       second: dtpwm_pkg::ActLow};
      cnt_q       <= '0;
      act_per_q   <= CntW'(dtpwm_pkg::ResetPeriod);
      shd_per_q   <= CntW'(dtpwm_pkg::ResetPeriod);
      for (int i = 0; i < 4; i++) begin
        act_cmp_q[i] <= '0;
        shd_cmp_q[i] <= '0;
      end
      lvl_a_q     <= 1'b0;
      lvl_b_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clk_rate_q  <= clk_rate_d;
      act_a_q     <= act_a_d;
      act_b_q     <= act_b_d;
      cnt_q       <= cnt_d;
      act_per_q   <= act_per_d;
      shd_per_q   <= shd_per_d;
      act_cmp_q   <= act_cmp_d;
      shd_cmp_q   <= shd_cmp_d;
      lvl_a_q     <= lvl_a_d;
      lvl_b_q     <= lvl_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk_i) begin
    dead_q       <= dead_d;
    per_q        <= per_d;
    diff_q       <= diff_d;
    sat_q        <= sat_d;
    rej_q        <= rej_d;
    out_a_q      <= out_a_d;
    out_b_q      <= out_b_d;
    out_cnt_q    <= out_cnt_d;
    out_pstart_q <= out_pstart_d;
    out_stat_q   <= out_stat_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pwm_a_o        = out_a_q;
  assign pwm_b_o        = out_b_q;
  assign count_o        = out_cnt_q;
  assign period_start_o = out_pstart_q;
  assign status_o       = out_stat_q;

endmodule

`default_nettype wire

>>> hw/rtl/dtpwm_div.sv
// Restoring divider, one quotient bit per cycle, for the period calculation.
`default_nettype none

module dtpwm_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [dtpwm_pkg::ClockW-1:0] dividend_i,
  input  wire logic [dtpwm_pkg::FreqW-1:0]  divisor_i,
  output logic                             done_o,
  output logic      [dtpwm_pkg::ClockW-1:0] quotient_o
);

  localparam int DvdW = dtpwm_pkg::ClockW;
  localparam int DvsW = dtpwm_pkg::FreqW;
  localparam int CntW = $clog2(DvdW);

  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvdW-1:0] quo_q, quo_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [DvsW:0]   trial;
  logic [DvsW:0]   trial_sub;
  logic            fits;

  always_comb begin
    trial     = {rem_q, quo_q[DvdW-1]};
    trial_sub = trial - {1'b0, dvs_q};
    fits      = trial >= {1'b0, dvs_q};

    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(DvdW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift one dividend bit into the remainder, subtract when it fits
      rem_d = fits ? trial_sub[DvsW-1:0] : trial[DvsW-1:0];
      quo_d = {quo_q[DvdW-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> hw/rtl/dtpwm_chan.sv
// Event resolution for one PWM output: zero, first and second compare.
`default_nettype none

module dtpwm_chan #(
  parameter int CmpW = 17
) (
  input  wire logic                 level_i,
  input  wire logic                 at_zero_i,
  input  wire logic [CmpW-1:0]      count_i,
  input  wire logic [CmpW-1:0]      cmp_first_i,
  input  wire logic [CmpW-1:0]      cmp_second_i,
  input  dtpwm_pkg::act_set_t       act_i,
  output logic                      level_o
);

  dtpwm_pkg::act_e act;
  logic            hit;

  always_comb begin
    // the later event in the period wins
    hit = 1'b1;
    act = dtpwm_pkg::ActNone;
    priority if (count_i == cmp_second_i) begin
      act = act_i.second;
    end else if (count_i == cmp_first_i) begin
      act = act_i.first;
    end else if (at_zero_i) begin
      act = act_i.zero;
    end else begin
      hit = 1'b0;
    end

    level_o = level_i;
    if (hit) begin
      unique case (act)
        dtpwm_pkg::ActNone:   level_o = level_i;
        dtpwm_pkg::ActLow:    level_o = 1'b0;
        dtpwm_pkg::ActHigh:   level_o = 1'b1;
        dtpwm_pkg::ActToggle: level_o = ~level_i;
        default:              level_o = level_i;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_dead_time_pwm_pair_generator.sv
// Self-checking testbench for the dead-time PWM pair generator.
module tb_dead_time_pwm_pair_generator;
  timeunit 1ns;
  timeprecision 1ps;

  // Largest period the 16-bit counter can hold; longer quotients clamp here.
  localparam longint unsigned CountMax =
    (longint'(1) << dtpwm_pkg::CounterBitsDef) - 1;

  // One output sample of the block, as the tracker expects it.
  typedef struct {
    bit                 pwm_a;
    bit                 pwm_b;
    bit [15:0]          count;
    bit                 period_start;
    dtpwm_pkg::status_e status;
  } bridge_sample_t;

  // Tracker of the half-bridge timer: keeps its own counter,
  // active and shadow period/compare sets, output levels and configuration,
  // and queues the sample each accepted transfer must produce.
  class half_bridge_timer;
    bit [27:0]           clock_rate;
    dtpwm_pkg::act_set_t acts[2];
    longint unsigned     count;
    longint unsigned     act_period;
    longint unsigned     shadow_period;
    longint unsigned     act_cmp[4];
    longint unsigned     shadow_cmp[4];
    bit                  levels[2];
    bridge_sample_t      pending_levels[$];
    int unsigned         faults;

    function new();
      clock_rate    = 28'(dtpwm_pkg::ResetClock);
      acts[0]       = '{zero: dtpwm_pkg::ActLow, first: dtpwm_pkg::ActHigh,
                        second: dtpwm_pkg::ActLow};
      acts[1]       = '{zero: dtpwm_pkg::ActLow, first: dtpwm_pkg::ActHigh,
                        second: dtpwm_pkg::ActLow};
      count         = 0;
      act_period    = dtpwm_pkg::ResetPeriod;
      shadow_period = dtpwm_pkg::ResetPeriod;
      for (int i = 0; i < 4; i++) begin
        act_cmp[i]    = 0;
        shadow_cmp[i] = 0;
      end
      levels[0] = 1'b0;
      levels[1] = 1'b0;
      faults    = 0;
    endfunction

    function void take_config(dtpwm_pkg::cfg_idx_e idx, logic [27:0] data);
      case (idx)
        dtpwm_pkg::CfgClockRate:  clock_rate     = data;
        dtpwm_pkg::CfgZeroActA:   acts[0].zero   = dtpwm_pkg::act_e'(data[1:0]);
        dtpwm_pkg::CfgFirstActA:  acts[0].first  = dtpwm_pkg::act_e'(data[1:0]);
        dtpwm_pkg::CfgSecondActA: acts[0].second = dtpwm_pkg::act_e'(data[1:0]);
        dtpwm_pkg::CfgZeroActB:   acts[1].zero   = dtpwm_pkg::act_e'(data[1:0]);
        dtpwm_pkg::CfgFirstActB:  acts[1].first  = dtpwm_pkg::act_e'(data[1:0]);
        dtpwm_pkg::CfgSecondActB: acts[1].second = dtpwm_pkg::act_e'(data[1:0]);
        default: ;
      endcase
    endfunction

    function void take_item(bit is_update, logic [23:0] freq, logic [9:0] dead);
      bridge_sample_t  s;
      longint unsigned p;
      longint unsigned half;
      bit              at_zero;
      s.status       = dtpwm_pkg::StatOk;
      s.period_start = 1'b0;
      if (is_update) begin
        // Zero frequency is refused before any division.
        if (freq == 0) begin
          s.status = dtpwm_pkg::StatReject;
        end else begin
          p = longint'(clock_rate) / longint'(freq);
          if (p > CountMax) begin
            p        = CountMax;
            s.status = dtpwm_pkg::StatSat;
          end
          // Dead time not below the period (a zero period included) is refused.
          if (longint'(dead) >= p) begin
            s.status = dtpwm_pkg::StatReject;
          end else begin
            half          = (p - dead) / 2;
            shadow_period = p;
            shadow_cmp[0] = 0;
            shadow_cmp[1] = half;
            shadow_cmp[2] = half + dead;
            shadow_cmp[3] = p - dead + 1;
          end
        end
      end else begin
        at_zero = 1'b0;
        if (count + 1 >= act_period) begin
          // Wrap: load the shadow set into the active set.
          count          = 0;
          at_zero        = 1'b1;
          s.period_start = 1'b1;
          act_period     = shadow_period;
          act_cmp        = shadow_cmp;
        end else begin
          count = count + 1;
        end
        for (int k = 0; k < 2; k++) begin
          dtpwm_pkg::act_e act;
          act = dtpwm_pkg::ActNone;
          // Later events override earlier ones on the same tick.
          if (at_zero) act = acts[k].zero;
          if (count == act_cmp[2*k]) act = acts[k].first;
          if (count == act_cmp[2*k+1]) act = acts[k].second;
          case (act)
            dtpwm_pkg::ActLow:    levels[k] = 1'b0;
            dtpwm_pkg::ActHigh:   levels[k] = 1'b1;
            dtpwm_pkg::ActToggle: levels[k] = ~levels[k];
            default: ;
          endcase
        end
      end
      s.pwm_a = levels[0];
      s.pwm_b = levels[1];
      s.count = count[15:0];
      pending_levels.push_back(s);
    endfunction

    function void check_sample(logic pwm_a, logic pwm_b, logic [15:0] cnt, logic pstart,
                               logic [1:0] status);
      bridge_sample_t e;
      if (pending_levels.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: unexpected result a=%0b b=%0b count=%0d start=%0b status=%0d",
                   $time, pwm_a, pwm_b, cnt, pstart, status);
        return;
      end
      e = pending_levels.pop_front();
      if (pwm_a !== e.pwm_a || pwm_b !== e.pwm_b || cnt !== e.count ||
          pstart !== e.period_start || status !== e.status) begin
        faults++;
        if (faults <= 10)
          $display({"%0t: mismatch exp a=%0b b=%0b count=%0d start=%0b status=%0d,",
                    " got a=%0b b=%0b count=%0d start=%0b status=%0d"},
                   $time, e.pwm_a, e.pwm_b, e.count, e.period_start, e.status,
                   pwm_a, pwm_b, cnt, pstart, status);
      end
    endfunction

    function int pending();
      return pending_levels.size();
    endfunction

    // Ticks still needed until the counter wraps to zero.
    function int ticks_to_wrap();
      if (count + 1 >= act_period) return 1;
      return int'(act_period - count);
    endfunction
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_we_i = 1'b0;
  logic [dtpwm_pkg::CfgIdxW-1:0]       cfg_idx_i = '0;
  logic [dtpwm_pkg::CfgDataW-1:0]      cfg_data_i = '0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic                                action_i = 1'b0;
  logic [dtpwm_pkg::FreqW-1:0]         freq_hz_i = '0;
  logic [dtpwm_pkg::DeadW-1:0]         dead_time_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic                                pwm_a_o;
  logic                                pwm_b_o;
  logic [dtpwm_pkg::CountOutW-1:0]     count_o;
  logic                                period_start_o;
  logic [dtpwm_pkg::StatusW-1:0]       status_o;

  half_bridge_timer track = new();

  // Clock rate the block currently holds; used to aim updates at small periods.
  longint unsigned clock_now = dtpwm_pkg::ResetClock;
  // Chance (percent) of starting an idle burst: per item on the input side, per cycle on the result side.
  int unsigned gap_pct = 15;
  int unsigned stall_pct = 15;
  int unsigned stall_left = 0;

  dead_time_pwm_pair_generator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .freq_hz_i      (freq_hz_i),
    .dead_time_i    (dead_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pwm_a_o        (pwm_a_o),
    .pwm_b_o        (pwm_b_o),
    .count_o        (count_o),
    .period_start_o (period_start_o),
    .status_o       (status_o)
  );

  always #4 clk_i = ~clk_i;

  // Hold off the result side in bursts of random length.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(13, 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Sample both channels at the edge: predict on every input transfer first,
  // then check the result transfer, so a same-cycle answer always finds its
  // expectation already queued.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        track.take_item(action_i, freq_hz_i, dead_time_i);
      if (out_valid_o && !out_stall_i)
        track.check_sample(pwm_a_o, pwm_b_o, count_o, period_start_o, status_o);
    end
  end

  // Present one item, optionally after an idle burst, and hold it until taken.
  task automatic send_item(bit act, logic [23:0] freq, logic [9:0] dead);
    int unsigned gap;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(14, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    freq_hz_i   <= freq;
    dead_time_i <= dead;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Tick with random don't-care payload so the field bits toggle.
  task automatic send_tick();
    send_item(1'b0, 24'($urandom), 10'($urandom));
  endtask

  // Update that is sure to pass: aim at a small period and keep the dead time
  // below it, with the frequency kept inside 24 bits.
  task automatic send_good_update();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned target;
    longint unsigned f;
    lo = clock_now / 24'hFFFFFF + 1;
    hi = (clock_now < 32) ? clock_now : 32;
    if (hi < lo) hi = lo;
    target = $urandom_range(int'(hi), int'(lo));
    f      = clock_now / target;
    send_item(1'b1, f[23:0], 10'($urandom_range(int'(target) - 1, 0)));
  endtask

  // Update with arbitrary content (may be refused or clamp), then restore a
  // small shadow period so no long period ever goes live.
  task automatic send_wild_update();
    logic [23:0] f;
    case ($urandom_range(2))
      0:       f = '0;
      1:       f = 24'($urandom);
      default: f = 24'($urandom_range(4000, 1));
    endcase
    send_item(1'b1, f, 10'($urandom));
    send_good_update();
  endtask

  // Mostly ticks, with updates mixed in at random points of the period.
  task automatic run_mix(int n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 84) send_tick();
      else if (r < 94) send_good_update();
      else send_wild_update();
    end
  endtask

  // Drop valid and wait until every expected result has come back. Advance
  // to the next edge first so the last transfer is already in the tracker.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (track.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(dtpwm_pkg::cfg_idx_e idx, logic [27:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    track.take_config(idx, data);
  endtask

  // Reconfigure the idle block and set the idling mix for the next phase.
  task automatic set_phase(logic [27:0] clock, dtpwm_pkg::act_set_t a,
                           dtpwm_pkg::act_set_t b, int unsigned gap,
                           int unsigned stall);
    settle();
    write_reg(dtpwm_pkg::CfgClockRate, clock);
    write_reg(dtpwm_pkg::CfgZeroActA, 28'(a.zero));
    write_reg(dtpwm_pkg::CfgFirstActA, 28'(a.first));
    write_reg(dtpwm_pkg::CfgSecondActA, 28'(a.second));
    write_reg(dtpwm_pkg::CfgZeroActB, 28'(b.zero));
    write_reg(dtpwm_pkg::CfgFirstActB, 28'(b.first));
    write_reg(dtpwm_pkg::CfgSecondActB, 28'(b.second));
    cfg_we_i  <= 1'b0;
    clock_now = clock;
    gap_pct   = gap;
    stall_pct = stall;
  endtask

  function automatic dtpwm_pkg::act_set_t any_acts();
    dtpwm_pkg::act_set_t s;
    s.zero   = dtpwm_pkg::act_e'($urandom_range(3));
    s.first  = dtpwm_pkg::act_e'($urandom_range(3));
    s.second = dtpwm_pkg::act_e'($urandom_range(3));
    return s;
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults, field extremes and the special cases.
    send_tick();
    send_item(1'b1, 24'd0, 10'd0);            // zero frequency: refuse
    send_item(1'b1, 24'hFFFFFF, 10'd0);       // shortest period at this clock
    send_item(1'b1, 24'd1, 10'h3FF);          // long period: clamp
    send_item(1'b1, 24'hFFFFFF, 10'h3FF);     // dead time beyond period: refuse
    send_item(1'b1, 24'd100000, 10'h3FF);     // widest dead time that fits
    // Leave a 9-tick period queued: compares A=0 (ties zero), A2=B1=4, B2 off.
    send_item(1'b1, 24'hFFFFFF, 10'd0);
    send_tick();
    send_tick();

    // Run out the reset period so the queued set goes live, then walk it.
    repeat (track.ticks_to_wrap()) send_tick();
    repeat (20) send_tick();

    // Random phases across the clock-rate and action extremes.
    run_mix(24);
    set_phase(28'd200000000,
              '{dtpwm_pkg::ActToggle, dtpwm_pkg::ActToggle, dtpwm_pkg::ActToggle},
              '{dtpwm_pkg::ActToggle, dtpwm_pkg::ActToggle, dtpwm_pkg::ActToggle},
              35, 10);
    run_mix(24);
    set_phase(28'd1,
              '{dtpwm_pkg::ActNone, dtpwm_pkg::ActNone, dtpwm_pkg::ActNone},
              '{dtpwm_pkg::ActNone, dtpwm_pkg::ActNone, dtpwm_pkg::ActNone},
              0, 0);
    run_mix(16);
    set_phase(28'($urandom_range(200000000, 1000)), any_acts(), any_acts(), 10, 40);
    run_mix(24);
    set_phase(28'($urandom_range(3000, 2)), any_acts(), any_acts(), 25, 25);
    run_mix(24);
    // Last stretch runs back to back with no idling on either side.
    set_phase(28'd160000000, any_acts(), any_acts(), 0, 0);
    run_mix(40);

    settle();
    repeat (40) @(posedge clk_i);
    if (track.faults == 0 && track.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
